FILE: design/tcma_pkg.sv
// Shared types, constants and SHA-256 helpers for the tag MAC authorizer.
`default_nettype none
package tcma_pkg;

    localparam int unsigned NUM_KEY_WORDS = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_BLANK = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    localparam logic OP_PROVISION = 1'b0;
    localparam logic OP_AUTHORIZE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 2'd3;

    // Which 512-bit block the compression unit loads.
    typedef enum logic [2:0] {
        BLK_IPAD,
        BLK_INNER_MSG,
        BLK_OPAD,
        BLK_OUTER_MSG
    } t_blk_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_NEXT,
        ST_DONE,
        ST_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic       capture;    // take the input beat
        logic       init_hash;  // load H with the SHA-256 IV
        logic       load_blk;   // load W window and working vars
        t_blk_sel   blk;
        logic       round;      // run one round
        logic       fold;       // add working vars into H
        logic       save_inner; // keep H as inner digest
        logic       save_ipad;  // keep H after key block (inner)
        logic       save_opad;  // keep H after key block (outer)
        logic       use_ipad;   // load H from saved ipad state
        logic       use_opad;   // load H from saved opad state
        logic       bump;       // counter + 1
        logic       save_mac;   // latch first digest word as MAC
        logic [1:0] status;
        logic       set_result;
        logic       zero_result;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic op;
        logic blank;
        logic mac_match;
        logic last_round;
    } t_sts;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] IPAD_WORD = 32'h36363636;
    localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
    // Message length in bits: 76 bytes inner, 96 bytes outer.
    localparam logic [31:0] INNER_BITS = 32'd608;
    localparam logic [31:0] OUTER_BITS = 32'd768;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] x);
        bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage
`default_nettype wire

FILE: design/tcma_if.sv
// Valid/ready channel interfaces for record and result beats.
`default_nettype none
interface tcma_rec_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] tag_id;
    logic [31:0] counter;
    logic [31:0] mac;
    modport source (output valid, output operation, output tag_id, output counter,
                    output mac, input ready);
    modport sink (input valid, input operation, input tag_id, input counter,
                  input mac, output ready);
endinterface

interface tcma_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        authorized;
    logic [31:0] new_counter;
    logic [31:0] new_mac;
    modport source (output valid, output status, output authorized,
                    output new_counter, output new_mac, input ready);
    modport sink (input valid, input status, input authorized,
                  input new_counter, input new_mac, output ready);
endinterface
`default_nettype wire

FILE: design/tcma_ctrl.sv
// Sequencer for the SHA-256 compressions of each HMAC: four on the first pass, three on the renewal pass.
`default_nettype none
module tcma_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire tcma_pkg::t_sts i_sts,
    output tcma_pkg::t_cmd     o_cmd
);

    tcma_pkg::t_state   r_state, n_state;
    tcma_pkg::t_blk_sel r_blk, n_blk;
    logic               r_second, n_second;
    logic               r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcma_pkg::ST_IDLE;
            r_blk       <= tcma_pkg::BLK_IPAD;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_blk       <= n_blk;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_blk       = r_blk;
        n_second    = r_second;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            tcma_pkg::ST_IDLE: begin
                if (i_in_valid && (!r_out_valid || i_out_ready)) begin
                    n_state  = tcma_pkg::ST_CHECK;
                    n_second = 1'b0;
                end
            end
            tcma_pkg::ST_CHECK: begin
                if (i_sts.op == tcma_pkg::OP_AUTHORIZE && i_sts.blank) begin
                    n_state = tcma_pkg::ST_OUT;
                end else begin
                    n_state = tcma_pkg::ST_LOAD;
                    n_blk   = tcma_pkg::BLK_IPAD;
                end
            end
            tcma_pkg::ST_LOAD: n_state = tcma_pkg::ST_ROUND;
            tcma_pkg::ST_ROUND: begin
                if (i_sts.last_round) begin
                    n_state = tcma_pkg::ST_FOLD;
                end
            end
            tcma_pkg::ST_FOLD: begin
                if (r_blk == tcma_pkg::BLK_OUTER_MSG) begin
                    n_state = tcma_pkg::ST_DONE;
                end else begin
                    n_state = tcma_pkg::ST_LOAD;
                    unique case (r_blk)
                        tcma_pkg::BLK_IPAD:      n_blk = tcma_pkg::BLK_INNER_MSG;
                        tcma_pkg::BLK_INNER_MSG: n_blk = tcma_pkg::BLK_OPAD;
                        default:                 n_blk = tcma_pkg::BLK_OUTER_MSG;
                    endcase
                end
            end
            tcma_pkg::ST_DONE: begin
                if (i_sts.op == tcma_pkg::OP_PROVISION || r_second) begin
                    n_state = tcma_pkg::ST_OUT;
                end else if (!i_sts.mac_match) begin
                    n_state = tcma_pkg::ST_OUT;
                end else begin
                    n_state  = tcma_pkg::ST_NEXT;
                    n_second = 1'b1;
                end
            end
            tcma_pkg::ST_NEXT: begin
                n_state = tcma_pkg::ST_LOAD;
                n_blk   = tcma_pkg::BLK_INNER_MSG;
            end
            tcma_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state     = tcma_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = tcma_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.blk = r_blk;
        o_in_ready = (r_state == tcma_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
        o_out_valid = r_out_valid;
        unique case (r_state)
            tcma_pkg::ST_IDLE: o_cmd.capture = o_in_ready && i_in_valid;
            tcma_pkg::ST_CHECK: o_cmd.init_hash = 1'b1;
            tcma_pkg::ST_LOAD: begin
                o_cmd.load_blk = 1'b1;
                o_cmd.use_ipad = (r_blk == tcma_pkg::BLK_INNER_MSG) && r_second;
                o_cmd.use_opad = (r_blk == tcma_pkg::BLK_OUTER_MSG);
                o_cmd.init_hash = (r_blk == tcma_pkg::BLK_OPAD);
            end
            tcma_pkg::ST_ROUND: o_cmd.round = 1'b1;
            tcma_pkg::ST_FOLD: begin
                o_cmd.fold       = 1'b1;
                o_cmd.save_ipad  = (r_blk == tcma_pkg::BLK_IPAD);
                o_cmd.save_inner = (r_blk == tcma_pkg::BLK_INNER_MSG);
                o_cmd.save_opad  = (r_blk == tcma_pkg::BLK_OPAD);
            end
            tcma_pkg::ST_DONE: o_cmd.save_mac = 1'b1;
            tcma_pkg::ST_NEXT: o_cmd.bump = 1'b1;
            tcma_pkg::ST_OUT: begin
                o_cmd.set_result = !r_out_valid || i_out_ready;
                if (i_sts.op == tcma_pkg::OP_AUTHORIZE && i_sts.blank) begin
                    o_cmd.status = tcma_pkg::STATUS_BLANK;
                    o_cmd.zero_result = 1'b1;
                end else if (i_sts.op == tcma_pkg::OP_AUTHORIZE && !r_second) begin
                    o_cmd.status = tcma_pkg::STATUS_MISMATCH;
                    o_cmd.zero_result = 1'b1;
                end else begin
                    o_cmd.status = tcma_pkg::STATUS_OK;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    a_one_pass_per_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcma_pkg::ST_IDLE && i_in_valid && o_in_ready) |=>
        r_state == tcma_pkg::ST_CHECK)
        else $error("accepted beat did not start a pass");
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result beat dropped while stalled");
    a_second_only_authorize: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcma_pkg::ST_NEXT) |-> (i_sts.op == tcma_pkg::OP_AUTHORIZE && i_sts.mac_match))
        else $error("renewal pass without a matching authorize");

endmodule
`default_nettype wire

FILE: design/tcma_datapath.sv
// SHA-256 round unit, message schedule, hash state and result register.
`default_nettype none
module tcma_datapath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tcma_pkg::t_cmd i_cmd,
    output tcma_pkg::t_sts      o_sts,
    input  wire logic [255:0]   i_key,
    input  wire logic           i_operation,
    input  wire logic [63:0]    i_tag_id,
    input  wire logic [31:0]    i_counter,
    input  wire logic [31:0]    i_mac,
    output logic [1:0]          o_status,
    output logic                o_authorized,
    output logic [31:0]         o_new_counter,
    output logic [31:0]         o_new_mac
);

    logic        r_op;
    logic [63:0] r_tag;
    logic [31:0] r_cnt;
    logic [31:0] r_mac_in;
    logic [31:0] r_mac_out;
    logic [255:0] r_h, r_ipad_h, r_opad_h, r_inner;
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;
    logic [5:0]  r_rnd;
    logic [1:0]  r_status;
    logic        r_auth;
    logic [31:0] r_res_cnt, r_res_mac;

    logic [511:0] blk_bits;
    logic [255:0] h_src;
    logic [31:0] t1, t2, w_new;

    always_comb begin
        blk_bits = '0;
        unique case (i_cmd.blk)
            tcma_pkg::BLK_IPAD:
                blk_bits = {i_key ^ {8{tcma_pkg::IPAD_WORD}}, {8{tcma_pkg::IPAD_WORD}}};
            tcma_pkg::BLK_OPAD:
                blk_bits = {i_key ^ {8{tcma_pkg::OPAD_WORD}}, {8{tcma_pkg::OPAD_WORD}}};
            tcma_pkg::BLK_INNER_MSG:
                blk_bits = {r_tag, tcma_pkg::bswap(r_cnt), 32'h80000000, 352'd0,
                            tcma_pkg::INNER_BITS};
            tcma_pkg::BLK_OUTER_MSG:
                blk_bits = {r_inner, 32'h80000000, 192'd0, tcma_pkg::OUTER_BITS};
            default: blk_bits = '0;
        endcase
        if (i_cmd.use_ipad) begin
            h_src = r_ipad_h;
        end else if (i_cmd.use_opad) begin
            h_src = r_opad_h;
        end else if (i_cmd.init_hash) begin
            h_src = tcma_pkg::INIT_H;
        end else begin
            h_src = r_h;
        end
        t1 = r_hh + tcma_pkg::bsig1(r_e) + ((r_e & r_f) ^ (~r_e & r_g))
             + tcma_pkg::ROUND_K[r_rnd] + r_w[0];
        t2 = tcma_pkg::bsig0(r_a) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
        w_new = r_w[0] + tcma_pkg::sig0(r_w[1]) + r_w[9] + tcma_pkg::sig1(r_w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_tag    <= i_tag_id;
            r_cnt    <= i_counter;
            r_mac_in <= i_mac;
        end
        if (i_cmd.bump) begin
            r_cnt <= r_cnt + 32'd1;
        end
        if (i_cmd.init_hash && !i_cmd.load_blk) begin
            r_h <= tcma_pkg::INIT_H;
        end
        if (i_cmd.load_blk) begin
            r_h <= h_src;
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh} <= h_src;
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= blk_bits[511 - 32*i -: 32];
            end
            r_rnd <= '0;
        end
        if (i_cmd.round) begin
            r_hh <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_rnd <= r_rnd + 6'd1;
        end
        if (i_cmd.fold) begin
            r_h <= {r_h[255:224] + r_a, r_h[223:192] + r_b, r_h[191:160] + r_c,
                    r_h[159:128] + r_d, r_h[127:96] + r_e, r_h[95:64] + r_f,
                    r_h[63:32] + r_g, r_h[31:0] + r_hh};
            if (i_cmd.save_ipad) begin
                r_ipad_h <= {r_h[255:224] + r_a, r_h[223:192] + r_b, r_h[191:160] + r_c,
                             r_h[159:128] + r_d, r_h[127:96] + r_e, r_h[95:64] + r_f,
                             r_h[63:32] + r_g, r_h[31:0] + r_hh};
            end
            if (i_cmd.save_opad) begin
                r_opad_h <= {r_h[255:224] + r_a, r_h[223:192] + r_b, r_h[191:160] + r_c,
                             r_h[159:128] + r_d, r_h[127:96] + r_e, r_h[95:64] + r_f,
                             r_h[63:32] + r_g, r_h[31:0] + r_hh};
            end
            if (i_cmd.save_inner) begin
                r_inner <= {r_h[255:224] + r_a, r_h[223:192] + r_b, r_h[191:160] + r_c,
                            r_h[159:128] + r_d, r_h[127:96] + r_e, r_h[95:64] + r_f,
                            r_h[63:32] + r_g, r_h[31:0] + r_hh};
            end
        end
        if (i_cmd.save_mac) begin
            r_mac_out <= r_h[255:224];
        end
        if (i_cmd.set_result) begin
            r_status <= i_cmd.status;
            r_auth   <= (r_op == tcma_pkg::OP_AUTHORIZE) && !i_cmd.zero_result;
            r_res_cnt <= i_cmd.zero_result ? 32'd0 : r_cnt;
            r_res_mac <= i_cmd.zero_result ? 32'd0 : r_mac_out;
        end
    end

    always_comb begin
        o_sts.op = r_op;
        o_sts.blank = ({r_tag, r_cnt, r_mac_in} == 128'd0) || (&{r_tag, r_cnt, r_mac_in});
        o_sts.mac_match = (r_h[255:224] == r_mac_in);
        o_sts.last_round = (r_rnd == 6'd63);
        o_status = r_status;
        o_authorized = r_auth;
        o_new_counter = r_res_cnt;
        o_new_mac = r_res_mac;
    end

    a_round_runs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.round && r_rnd != 6'd63) |=> r_rnd == $past(r_rnd) + 6'd1)
        else $error("round counter skipped");
    a_ok_has_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_result |-> (i_cmd.zero_result == (i_cmd.status != tcma_pkg::STATUS_OK)))
        else $error("result status and zeroing disagree");
    a_load_not_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load_blk && i_cmd.round))
        else $error("load and round in the same cycle");

endmodule
`default_nettype wire

FILE: design/tag_counter_mac_authorizer.sv
// Top level of the tag counter MAC authorizer: key registers, controller, datapath.
//  channel  | dir | beat
//  rec      | in  | operation, tag_id[63:0], counter[31:0], mac[31:0]
//  res      | out | status[1:0], authorized, new_counter[31:0], new_mac[31:0]
//  cfg      | in  | i_cfg_we, i_cfg_idx[1:0], i_cfg_data[63:0] (key words 0..3)
// Blank authorize record: result without any compression. Provision and MAC check:
// four compressions. Authorize with a match renews over three more
// compressions, one beat at a time.
// The single SHA-256 round unit runs one round per cycle.
// Reset (synchronous, active low) clears the key to zero and empties the result.
// A stalled result holds; the next record is taken only as the result leaves.
`default_nettype none
module tag_counter_mac_authorizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tcma_rec_if.sink         i_rec,
    tcma_res_if.source       o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [tcma_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    logic [63:0] r_key [tcma_pkg::NUM_KEY_WORDS];
    tcma_pkg::t_cmd cmd;
    tcma_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tcma_pkg::NUM_KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcma_pkg::REG_KEY_WORD_0: r_key[0] <= i_cfg_data;
                tcma_pkg::REG_KEY_WORD_1: r_key[1] <= i_cfg_data;
                tcma_pkg::REG_KEY_WORD_2: r_key[2] <= i_cfg_data;
                tcma_pkg::REG_KEY_WORD_3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rec.valid),
        .o_in_ready  (i_rec.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tcma_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_key         ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_operation   (i_rec.operation),
        .i_tag_id      (i_rec.tag_id),
        .i_counter     (i_rec.counter),
        .i_mac         (i_rec.mac),
        .o_status      (o_res.status),
        .o_authorized  (o_res.authorized),
        .o_new_counter (o_res.new_counter),
        .o_new_mac     (o_res.new_mac)
    );

endmodule
`default_nettype wire
